// File: design/smm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// smm_pkg
// Shared types and constants for the sample min/max/mean core.
// ============================================================================
package smm_pkg;

  // Default widths for the top-level parameters
  localparam int CODE_BITS_DEF  = 24;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed width of the discard register
  localparam int DISCARD_BITS = 8;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DISCARD_COUNT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT  = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_FINISH
  } smm_state_t;

  // Commands from the sequencer to the statistics registers
  typedef struct packed {
    logic update;
    logic clear;
  } smm_stats_ctl_t;

endpackage

// File: design/sample_min_max_mean_core.sv
`timescale 1ns / 1ps
// ============================================================================
// sample_min_max_mean_core
// Run statistics over signed converter codes: minimum, maximum and mean.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_ready  | in_sample_code
//  out_    | output    | out_valid/out_ready| out_min_value, out_max_value,
//          |           |                    | out_mean_value
//  cfg_    | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
//  Each sample transaction is accepted in the idle step, then makes one pass
//  through the compare/add update of the statistics registers.
//  The closing sample of a run then passes through the load step, the
//  one-bit-per-cycle restoring divider and the wait step that sees it done,
//  then the finish step moves the result into the output register.
//  The output register holds a result until taken; the next run proceeds
//  meanwhile and stalls only in the finish step if a second result is ready.
//  Reset (synchronous, active low) clears the run and sets discard_count to 0
//  and sample_count to 1; there is no clearing pass.
//
// ============================================================================
module sample_min_max_mean_core
  import smm_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int CFG_DATA_BITS = (COUNT_BITS > DISCARD_BITS) ? COUNT_BITS : DISCARD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample transactions
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [CODE_BITS-1:0]     in_sample_code,
  // result transactions
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [CODE_BITS-1:0]     out_min_value,
  output logic signed [CODE_BITS-1:0]     out_max_value,
  output logic signed [CODE_BITS-1:0]     out_mean_value,
  // configuration writes
  input  logic                            cfg_we,
  input  logic        [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic        [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int SUM_BITS = CODE_BITS + COUNT_BITS;

  smm_state_t                  state_r, state_nxt;
  smm_stats_ctl_t              stats_ctl;

  logic [DISCARD_BITS-1:0]     discard_count_r;
  logic [COUNT_BITS-1:0]       sample_count_r;
  logic [COUNT_BITS-1:0]       eff_count;

  logic signed [CODE_BITS-1:0] sample_r;

  logic                        run_last;
  logic signed [CODE_BITS-1:0] running_min;
  logic signed [CODE_BITS-1:0] running_max;
  logic        [SUM_BITS-1:0]  running_sum;

  logic                        div_start;
  logic                        div_busy;
  logic signed [CODE_BITS-1:0] div_quotient;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;
  logic signed [CODE_BITS-1:0] out_min_r, out_max_r, out_mean_r;

  // --------------------------------------------------------------------------
  // Configuration registers; a zero sample count acts as one
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_count_r <= '0;
      sample_count_r  <= COUNT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISCARD_COUNT: discard_count_r <= cfg_wdata[DISCARD_BITS-1:0];
        CFG_SAMPLE_COUNT:  sample_count_r  <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_count = (sample_count_r == '0) ? COUNT_BITS'(1) : sample_count_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    in_ready         = 1'b0;
    stats_ctl.update = 1'b0;
    stats_ctl.clear  = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // fold the captured sample in; the closing sample starts the divide
        stats_ctl.update = 1'b1;
        state_nxt = run_last ? ST_DIV_LOAD : ST_IDLE;
      end
      ST_DIV_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free, then drop the run state
        if (!out_valid_r || out_ready) begin
          out_load        = 1'b1;
          stats_ctl.clear = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // capture the sample at acceptance; the update runs next cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) sample_r <= in_sample_code;
  end

  // --------------------------------------------------------------------------
  // Statistics registers and divider
  // --------------------------------------------------------------------------
  smm_stats #(
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (stats_ctl),
    .sample        (sample_r),
    .discard_count (discard_count_r),
    .eff_count     (eff_count),
    .run_last      (run_last),
    .running_min   (running_min),
    .running_max   (running_max),
    .running_sum   (running_sum)
  );

  smm_divider #(
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (eff_count),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r  <= running_min;
      out_max_r  <= running_max;
      out_mean_r <= div_quotient;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_min_value  = out_min_r;
  assign out_max_value  = out_max_r;
  assign out_mean_value = out_mean_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider did not start after load");

  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy && in_ready))
    else $error("sample accepted while divider busy");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish step");
`endif

endmodule

// File: design/smm_stats.sv
`timescale 1ns / 1ps
// ============================================================================
// smm_stats
// Running minimum, maximum, sum and run position, one update per command.
// ============================================================================
module smm_stats
  import smm_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  smm_stats_ctl_t                         ctl,
  input  logic signed [CODE_BITS-1:0]            sample,
  input  logic        [DISCARD_BITS-1:0]         discard_count,
  input  logic        [COUNT_BITS-1:0]           eff_count,
  output logic                                   run_last,
  output logic signed [CODE_BITS-1:0]            running_min,
  output logic signed [CODE_BITS-1:0]            running_max,
  output logic        [CODE_BITS+COUNT_BITS-1:0] running_sum
);

  localparam int SUM_BITS  = CODE_BITS + COUNT_BITS;
  localparam int POS_BITS  = COUNT_BITS + 1;
  localparam int LAST_BITS = ((COUNT_BITS > DISCARD_BITS) ? COUNT_BITS : DISCARD_BITS) + 1;

  localparam logic signed [CODE_BITS-1:0] CODE_MAX = {1'b0, {(CODE_BITS-1){1'b1}}};
  localparam logic signed [CODE_BITS-1:0] CODE_MIN = {1'b1, {(CODE_BITS-1){1'b0}}};

  logic        [POS_BITS-1:0]  position_r, position_nxt;
  logic signed [CODE_BITS-1:0] min_r, min_nxt;
  logic signed [CODE_BITS-1:0] max_r, max_nxt;
  logic        [SUM_BITS-1:0]  sum_r, sum_nxt;
  logic        [LAST_BITS-1:0] pos_ext;
  logic        [LAST_BITS-1:0] last_pos;
  logic                        counted;

  assign pos_ext  = LAST_BITS'(position_r);
  assign last_pos = LAST_BITS'(discard_count) + LAST_BITS'(eff_count) - LAST_BITS'(1);
  assign counted  = pos_ext >= LAST_BITS'(discard_count);
  assign run_last = pos_ext >= last_pos;

  always_comb begin
    position_nxt = position_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    sum_nxt      = sum_r;
    if (ctl.clear) begin
      position_nxt = '0;
      min_nxt      = CODE_MAX;
      max_nxt      = CODE_MIN;
      sum_nxt      = '0;
    end else if (ctl.update) begin
      if (counted) begin
        if (sample < min_r) min_nxt = sample;
        if (sample > max_r) max_nxt = sample;
        sum_nxt = sum_r + {{COUNT_BITS{sample[CODE_BITS-1]}}, sample};
      end
      // hold position on the closing sample; clear resets it
      if (!run_last) position_nxt = position_r + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      min_r      <= CODE_MAX;
      max_r      <= CODE_MIN;
      sum_r      <= '0;
    end else begin
      position_r <= position_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      sum_r      <= sum_nxt;
    end
  end

  assign running_min = min_r;
  assign running_max = max_r;
  assign running_sum = sum_r;

endmodule

// File: design/smm_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// smm_divider
// Restoring divider, one quotient bit per cycle, signed dividend truncated
// toward zero and saturated to the code range.
// ============================================================================
module smm_divider
  import smm_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic        [CODE_BITS+COUNT_BITS-1:0] dividend,
  input  logic        [COUNT_BITS-1:0]           divisor,
  output logic                                   busy,
  output logic signed [CODE_BITS-1:0]            quotient
);

  localparam int SUM_BITS  = CODE_BITS + COUNT_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  localparam logic signed [CODE_BITS-1:0] CODE_MAX = {1'b0, {(CODE_BITS-1){1'b1}}};
  localparam logic signed [CODE_BITS-1:0] CODE_MIN = {1'b1, {(CODE_BITS-1){1'b0}}};

  logic [SUM_BITS-1:0]   acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] div_r;
  logic                  neg_r;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic                  q_high;

  assign trial = {rem_r, acc_r[SUM_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;
      rem_nxt  = '0;
      step_nxt = STEP_BITS'(SUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // the remainder stays below the divisor, so it fits COUNT_BITS
      rem_nxt  = fits ? COUNT_BITS'(trial - {1'b0, div_r}) : trial[COUNT_BITS-1:0];
      acc_nxt  = {acc_r[SUM_BITS-2:0], fits};
      step_nxt = step_r - STEP_BITS'(1);
      if (step_r == STEP_BITS'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
      neg_r <= dividend[SUM_BITS-1];
    end
  end

  // magnitude at or above half the code range saturates
  assign q_high = |acc_r[SUM_BITS-1:CODE_BITS-1];

  always_comb begin
    if (q_high) begin
      quotient = neg_r ? CODE_MIN : CODE_MAX;
    end else if (neg_r) begin
      quotient = -$signed(acc_r[CODE_BITS-1:0]);
    end else begin
      quotient = $signed(acc_r[CODE_BITS-1:0]);
    end
  end

  assign busy = busy_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the sample min/max/mean core.
// Sample codes flow from a queue through a clocked valid/ready driver; a
// clocked monitor folds every accepted code into a local model of the run
// statistics and compares each accepted result with the oldest one due.
// Register settings change only while the core is idle. The run walks
// through idle/stall mixes and a long output hold-off that backs up the core.
// ============================================================================
module tb_top;
  import smm_pkg::*;

  localparam int CODE_W = CODE_BITS_DEF;
  localparam int COUNT_W = COUNT_BITS_DEF;
  localparam int SUM_W = CODE_W + COUNT_W;
  localparam int CFG_W = (COUNT_W > DISCARD_BITS) ? COUNT_W : DISCARD_BITS;
  localparam logic signed [CODE_W-1:0] CODE_MAX = {1'b0, {(CODE_W-1){1'b1}}};
  localparam logic signed [CODE_W-1:0] CODE_MIN = {1'b1, {(CODE_W-1){1'b0}}};
  // closing sample: accept, update, load, divide, wait and finish, plus margin
  localparam int SETTLE_CYCLES = CODE_W + COUNT_W + 24;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic signed [CODE_W-1:0] min_v;
    logic signed [CODE_W-1:0] max_v;
    logic signed [CODE_W-1:0] mean_v;
  } run_stats_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [CODE_W-1:0] in_sample_code = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CODE_W-1:0] out_min_value;
  logic signed [CODE_W-1:0] out_max_value;
  logic signed [CODE_W-1:0] out_mean_value;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_DISCARD_COUNT;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_min_max_mean_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_code (in_sample_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_max_value  (out_max_value),
    .out_mean_value (out_mean_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic signed [CODE_W-1:0] code_queue[$];  // codes waiting for the driver
  run_stats_t               stats_due[$];   // run results not yet seen
  int                       n_pushed = 0;
  int                       n_taken = 0;
  int                       mismatches = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  logic                     hold_go = 1'b0;
  logic                     holding = 1'b0;

  // Local copy of the registers and the run in progress
  logic [DISCARD_BITS-1:0]  discard_reg;
  logic [COUNT_W-1:0]       count_reg;
  logic [COUNT_W:0]         run_pos;
  logic signed [CODE_W-1:0] run_min;
  logic signed [CODE_W-1:0] run_max;
  logic signed [SUM_W-1:0]  run_sum;

  function automatic void clear_run_stats();
    run_pos = '0;
    run_min = CODE_MAX;
    run_max = CODE_MIN;
    run_sum = '0;
  endfunction

  // Fold one accepted code into the run; on the closing code queue the
  // min/max/mean it yields and start a fresh run.
  function automatic void fold_code(input logic signed [CODE_W-1:0] code);
    int         eff_count;
    int         last_pos;
    longint     quotient;
    run_stats_t done;
    // a zero sample count behaves as one
    eff_count = (count_reg == 0) ? 1 : int'(count_reg);
    // the registers in force now decide where the run ends
    last_pos = int'(discard_reg) + eff_count - 1;
    if (int'(run_pos) >= int'(discard_reg)) begin
      if (code < run_min) run_min = code;
      if (code > run_max) run_max = code;
      run_sum = run_sum + code;  // wraps at the sum width
    end
    if (int'(run_pos) < last_pos) begin
      run_pos = run_pos + 1'b1;
    end else begin
      // integer division truncates toward zero; clamp to the code range
      quotient = longint'(run_sum) / eff_count;
      if (quotient > longint'(CODE_MAX)) quotient = longint'(CODE_MAX);
      if (quotient < longint'(CODE_MIN)) quotient = longint'(CODE_MIN);
      done.min_v = run_min;
      done.max_v = run_max;
      done.mean_v = quotient[CODE_W-1:0];
      stats_due.push_back(done);
      clear_run_stats();
    end
  endfunction

  task automatic check_field(input string field, input logic signed [CODE_W-1:0] want_v,
                             input logic signed [CODE_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold valid and payload until the transaction completes, then
  // offer the next queued code unless this cycle is picked to idle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (code_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_sample_code <= code_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and throughout a hold-off stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hold-off: keep ready low long enough for the core to back up its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict on every accepted sample
  // transaction, and check every accepted result transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    run_stats_t want;
    if (!rst_n) begin
      discard_reg = '0;
      count_reg = 1;
      clear_run_stats();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DISCARD_COUNT) discard_reg = cfg_wdata[DISCARD_BITS-1:0];
        else if (cfg_index == CFG_SAMPLE_COUNT) count_reg = cfg_wdata[COUNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        fold_code(in_sample_code);
        n_taken++;
      end
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual min %0d max %0d mean %0d",
                   $time, out_min_value, out_max_value, out_mean_value);
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          check_field("min_value", want.min_v, out_min_value);
          check_field("max_value", want.max_v, out_max_value);
          check_field("mean_value", want.mean_v, out_mean_value);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_code(input logic signed [CODE_W-1:0] code);
    code_queue.push_back(code);
    n_pushed++;
  endtask

  // Wait until every code is taken and every result seen, then give the
  // core time to go idle before registers change.
  task automatic settle();
    while (n_taken != n_pushed || stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mix of rail codes, codes near zero and full-range noise
  function automatic logic signed [CODE_W-1:0] random_code();
    int          near;
    logic [31:0] raw;
    near = $urandom_range(0, 16);
    near = near - 8;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0: return CODE_MAX;
      1: return CODE_MIN;
      2, 3: return near[CODE_W-1:0];
      default: return raw[CODE_W-1:0];
    endcase
  endfunction

  initial begin
    int d;
    int c;
    int len;
    int runs;
    int n;
    int n_rand;
    int blk;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: every code is a run of one
    push_code(CODE_MAX);
    push_code(CODE_MIN);
    push_code(0);
    push_code(-1);
    settle();

    // A zero sample count acts as one
    cfg_write(CFG_SAMPLE_COUNT, 0);
    push_code(5);
    push_code(-7);
    settle();

    // Skip two codes, then average both rails and a small value
    cfg_write(CFG_DISCARD_COUNT, 2);
    cfg_write(CFG_SAMPLE_COUNT, 3);
    push_code(100);
    push_code(200);
    push_code(CODE_MIN);
    push_code(CODE_MAX);
    push_code(3);
    settle();

    // Negative mean truncates toward zero
    cfg_write(CFG_DISCARD_COUNT, 0);
    cfg_write(CFG_SAMPLE_COUNT, 2);
    push_code(-3);
    push_code(0);
    settle();

    // Shrink the count mid-run so the mean clamps at both rails
    cfg_write(CFG_SAMPLE_COUNT, 4);
    repeat (3) push_code(CODE_MAX);
    settle();
    cfg_write(CFG_SAMPLE_COUNT, 1);
    push_code(CODE_MAX);
    settle();
    cfg_write(CFG_SAMPLE_COUNT, 4);
    repeat (3) push_code(CODE_MIN);
    settle();
    cfg_write(CFG_SAMPLE_COUNT, 1);
    push_code(CODE_MIN);
    settle();

    // Drop the discard count mid-run: only the code after the change counts
    cfg_write(CFG_DISCARD_COUNT, 5);
    cfg_write(CFG_SAMPLE_COUNT, 2);
    push_code(11);
    push_code(22);
    push_code(33);
    settle();
    cfg_write(CFG_DISCARD_COUNT, 0);
    push_code(44);
    settle();

    // Back-pressure: one result per code while the receiver holds off
    cfg_write(CFG_SAMPLE_COUNT, 1);
    hold_go = 1'b1;
    repeat (60) push_code(random_code());
    settle();

    // Random runs, rotating through the idle/stall mixes
    n_rand = 0;
    blk = 0;
    while (n_rand < RANDOM_ITEMS) begin
      case (blk % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      // favor short runs so results come often
      case ($urandom_range(0, 19))
        0: d = $urandom_range(0, 255);
        1, 2, 3, 4, 5: d = $urandom_range(4, 20);
        default: d = $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 19))
        0: c = $urandom_range(41, 300);
        1, 2: c = 0;
        3, 4, 5, 6: c = $urandom_range(9, 40);
        default: c = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_DISCARD_COUNT, d);
        cfg_write(CFG_SAMPLE_COUNT, c);
      end else begin
        cfg_write(CFG_SAMPLE_COUNT, c);
        cfg_write(CFG_DISCARD_COUNT, d);
      end
      len = d + ((c == 0) ? 1 : c);
      runs = (len > 100) ? 1 : $urandom_range(1, 4);
      n = runs * len;
      // now and then leave a run open across the next register change
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, len);
      repeat (n) push_code(random_code());
      n_rand += n;
      settle();
      blk++;
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout: several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
design/smm_pkg.sv
design/smm_stats.sv
design/smm_divider.sv
design/sample_min_max_mean_core.sv
tb/tb_top.sv
